// ===== src/msl_pkg.sv =====
`timescale 1ns / 1ps

package msl_pkg;

	localparam int NUM_LINES_DEF = 1024;

	localparam int OP_W    = 3;
	localparam int LIDX_W  = 10;
	localparam int ADDR_W  = 32;
	localparam int ID_W    = 4;
	localparam int REQ_W   = 2;
	localparam int ERR_W   = 2;
	localparam int STATE_W = 3;

	localparam logic [STATE_W-1:0] ST_I  = 3'd0;
	localparam logic [STATE_W-1:0] ST_IS = 3'd1;
	localparam logic [STATE_W-1:0] ST_S  = 3'd2;
	localparam logic [STATE_W-1:0] ST_E  = 3'd3;
	localparam logic [STATE_W-1:0] ST_IM = 3'd4;
	localparam logic [STATE_W-1:0] ST_SM = 3'd5;
	localparam logic [STATE_W-1:0] ST_M  = 3'd6;

	localparam logic [OP_W-1:0] OP_LOAD  = 3'd0;
	localparam logic [OP_W-1:0] OP_STORE = 3'd1;
	localparam logic [OP_W-1:0] OP_GETS  = 3'd2;
	localparam logic [OP_W-1:0] OP_GETM  = 3'd3;
	localparam logic [OP_W-1:0] OP_DATA  = 3'd4;

	localparam logic [REQ_W-1:0] REQ_NONE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_GETS = 2'd1;
	localparam logic [REQ_W-1:0] REQ_GETM = 2'd2;

	localparam logic [ERR_W-1:0] ERR_OK     = 2'd0;
	localparam logic [ERR_W-1:0] ERR_ACCESS = 2'd1;
	localparam logic [ERR_W-1:0] ERR_DATA   = 2'd2;
	localparam logic [ERR_W-1:0] ERR_UNEXP  = 2'd3;

endpackage

// ===== src/mesi_snooping_line_controller.sv =====
// Path: input registered in stage 1 (quotient), state read into stage 2 (next state
// computed and written back), then result in the output register. in_stall holds
// off input while stage 1 or 2 is busy, so a single line-state read-modify-write
// through the state memory is in flight at a time. Reset: own_id clears to 0; a
// clearing pass writes Invalid to all NUM_LINES entries, one per cycle, in_stall high.
`timescale 1ns / 1ps

module mesi_snooping_line_controller #(
	parameter int NUM_LINES = msl_pkg::NUM_LINES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [msl_pkg::ID_W-1:0]      cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [msl_pkg::OP_W-1:0]      opcode,
	input  logic [msl_pkg::LIDX_W-1:0]    line_index,
	input  logic [msl_pkg::ADDR_W-1:0]    address,
	input  logic [msl_pkg::ID_W-1:0]      source_id,
	input  logic                          shared_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [msl_pkg::REQ_W-1:0]     bus_request,
	output logic [msl_pkg::ADDR_W-1:0]    out_address,
	output logic                          data_to_processor,
	output logic                          data_on_bus,
	output logic [msl_pkg::ID_W-1:0]      data_destination,
	output logic                          assert_shared,
	output logic                          miss_mark,
	output logic                          silent_upgrade_mark,
	output logic [msl_pkg::ERR_W-1:0]     error_code,
	output logic [msl_pkg::STATE_W-1:0]   new_state
);

	localparam int IDX_W  = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
	localparam int LW     = msl_pkg::LIDX_W;
	localparam int RSH    = 2 * LW;
	localparam bit WRAP   = (NUM_LINES < (1 << LW));
	localparam logic [RSH:0] RECIP =
		WRAP ? (RSH+1)'(((1 << RSH) + NUM_LINES - 1) / NUM_LINES) : '0;
	localparam logic [LW-1:0] NMOD = WRAP ? LW'(NUM_LINES) : '0;

	// state memory
	logic [msl_pkg::STATE_W-1:0] mem [0:NUM_LINES-1];

	logic             clearing_q;
	logic [IDX_W-1:0] clr_cnt_q;
	logic [msl_pkg::ID_W-1:0] own_id_q;

	// stage 1: quotient of line index by NUM_LINES
	logic                          valid_s1;
	logic [msl_pkg::OP_W-1:0]      op_s1;
	logic [LW-1:0]                 x_s1;
	logic [LW-1:0]                 q_s1;
	logic [msl_pkg::ADDR_W-1:0]    addr_s1;
	logic [msl_pkg::ID_W-1:0]      src_s1;
	logic                          shared_s1;

	// stage 2: state read data available, compute and write back
	logic                          valid_s2;
	logic [msl_pkg::OP_W-1:0]      op_s2;
	logic [IDX_W-1:0]              idx_s2;
	logic [msl_pkg::ADDR_W-1:0]    addr_s2;
	logic [msl_pkg::ID_W-1:0]      src_s2;
	logic                          shared_s2;
	logic [msl_pkg::STATE_W-1:0]   rdata_s2;

	logic                          out_valid_q;
	logic [msl_pkg::REQ_W-1:0]     req_q;
	logic [msl_pkg::ADDR_W-1:0]    oaddr_q;
	logic                          to_proc_q;
	logic                          on_bus_q;
	logic [msl_pkg::ID_W-1:0]      dest_q;
	logic                          ash_q;
	logic                          miss_q;
	logic                          silent_q;
	logic [msl_pkg::ERR_W-1:0]     err_q;
	logic [msl_pkg::STATE_W-1:0]   nst_q;

	logic              in_acc;
	logic              s2_adv;
	logic [RSH+LW:0]   prod;
	logic [2*LW-1:0]   qn;
	logic [LW-1:0]     rem;
	logic [IDX_W-1:0]  rd_idx;

	logic [msl_pkg::STATE_W-1:0]   st;
	logic [msl_pkg::STATE_W-1:0]   nx;
	logic [msl_pkg::REQ_W-1:0]     req;
	logic [msl_pkg::ERR_W-1:0]     err;
	logic                          to_proc;
	logic                          on_bus;
	logic                          ash;
	logic                          miss;
	logic                          silent;
	logic                          store;

	assign cfg_ready = 1'b1;
	assign in_stall  = clearing_q | valid_s1 | valid_s2;
	assign in_acc    = in_valid & ~in_stall;
	assign s2_adv    = valid_s2 & (~out_valid_q | ~out_stall);

	assign prod   = line_index * RECIP;
	assign qn     = q_s1 * NMOD;
	assign rem    = x_s1 - qn[LW-1:0];
	assign rd_idx = IDX_W'(rem);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			own_id_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			if (clr_cnt_q == IDX_W'(NUM_LINES - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= in_acc;
			if (valid_s1) begin
				valid_s2 <= 1'b1;
			end else if (s2_adv) begin
				valid_s2 <= 1'b0;
			end
			if (s2_adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1     <= opcode;
			x_s1      <= line_index;
			q_s1      <= prod[RSH+LW-1:RSH];
			addr_s1   <= address;
			src_s1    <= source_id;
			shared_s1 <= shared_in;
		end
		if (valid_s1) begin
			op_s2     <= op_s1;
			idx_s2    <= rd_idx;
			addr_s2   <= addr_s1;
			src_s2    <= src_s1;
			shared_s2 <= shared_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rdata_s2 <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_cnt_q] <= msl_pkg::ST_I;
		end else if (s2_adv) begin
			mem[idx_s2] <= nx;
		end
	end

	assign st    = rdata_s2;
	assign store = (op_s2 == msl_pkg::OP_STORE);

	always_comb begin
		nx      = st;
		req     = msl_pkg::REQ_NONE;
		err     = msl_pkg::ERR_OK;
		to_proc = 1'b0;
		on_bus  = 1'b0;
		ash     = 1'b0;
		miss    = 1'b0;
		silent  = 1'b0;
		if (op_s2 > msl_pkg::OP_DATA) begin
			err = msl_pkg::ERR_UNEXP;
		end else if (op_s2 == msl_pkg::OP_LOAD || store) begin
			unique case (st)
				msl_pkg::ST_I: begin
					req  = store ? msl_pkg::REQ_GETM : msl_pkg::REQ_GETS;
					nx   = store ? msl_pkg::ST_IM : msl_pkg::ST_IS;
					miss = 1'b1;
				end
				msl_pkg::ST_S: begin
					if (store) begin
						req  = msl_pkg::REQ_GETM;
						nx   = msl_pkg::ST_SM;
						miss = 1'b1;
					end else begin
						to_proc = 1'b1;
					end
				end
				msl_pkg::ST_E: begin
					to_proc = 1'b1;
					if (store) begin
						nx     = msl_pkg::ST_M;
						silent = 1'b1;
					end
				end
				msl_pkg::ST_M: begin
					to_proc = 1'b1;
				end
				default: begin
					err = msl_pkg::ERR_ACCESS;
				end
			endcase
		end else begin
			unique case (st)
				msl_pkg::ST_I: begin
				end
				msl_pkg::ST_IS: begin
					if (op_s2 == msl_pkg::OP_DATA) begin
						to_proc = 1'b1;
						nx      = shared_s2 ? msl_pkg::ST_S : msl_pkg::ST_E;
					end
				end
				msl_pkg::ST_IM: begin
					if (op_s2 == msl_pkg::OP_DATA) begin
						to_proc = 1'b1;
						nx      = msl_pkg::ST_M;
					end
				end
				msl_pkg::ST_SM: begin
					priority if (op_s2 == msl_pkg::OP_GETS) begin
						ash = 1'b1;
					end else if (op_s2 == msl_pkg::OP_GETM) begin
						if (src_s2 != own_id_q) begin
							nx = msl_pkg::ST_IM;
						end
					end else begin
						to_proc = 1'b1;
						nx      = msl_pkg::ST_M;
					end
				end
				msl_pkg::ST_S: begin
					priority if (op_s2 == msl_pkg::OP_GETS) begin
						ash = 1'b1;
					end else if (op_s2 == msl_pkg::OP_GETM) begin
						nx = msl_pkg::ST_I;
					end else begin
						err = msl_pkg::ERR_DATA;
					end
				end
				default: begin
					priority if (op_s2 == msl_pkg::OP_GETS) begin
						ash    = 1'b1;
						on_bus = 1'b1;
						nx     = msl_pkg::ST_S;
					end else if (op_s2 == msl_pkg::OP_GETM) begin
						on_bus = 1'b1;
						nx     = msl_pkg::ST_I;
					end else begin
						err = msl_pkg::ERR_DATA;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			req_q     <= req;
			oaddr_q   <= (req != msl_pkg::REQ_NONE || to_proc || on_bus) ? addr_s2 : '0;
			to_proc_q <= to_proc;
			on_bus_q  <= on_bus;
			dest_q    <= on_bus ? src_s2 : '0;
			ash_q     <= ash;
			miss_q    <= miss;
			silent_q  <= silent;
			err_q     <= err;
			nst_q     <= nx;
		end
	end

	assign out_valid           = out_valid_q;
	assign bus_request         = req_q;
	assign out_address         = oaddr_q;
	assign data_to_processor   = to_proc_q;
	assign data_on_bus         = on_bus_q;
	assign data_destination    = dest_q;
	assign assert_shared       = ash_q;
	assign miss_mark           = miss_q;
	assign silent_upgrade_mark = silent_q;
	assign error_code          = err_q;
	assign new_state           = nst_q;

endmodule

// ===== src/msl_checker.sv =====
`timescale 1ns / 1ps

module msl_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [msl_pkg::REQ_W-1:0]     bus_request,
	input logic [msl_pkg::ADDR_W-1:0]    out_address,
	input logic                          data_to_processor,
	input logic                          data_on_bus,
	input logic [msl_pkg::ID_W-1:0]      data_destination,
	input logic                          miss_mark,
	input logic [msl_pkg::ERR_W-1:0]     error_code
);

	// one transaction in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a transaction is in flight");

	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != msl_pkg::ERR_OK |->
			bus_request == msl_pkg::REQ_NONE && !data_to_processor && !data_on_bus
			&& out_address == '0)
		else $error("error result carries activity");

	a_dest_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !data_on_bus |-> data_destination == '0)
		else $error("destination set without bus data");

	a_miss_req: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && miss_mark |-> bus_request != msl_pkg::REQ_NONE)
		else $error("miss without bus request");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_address)
			&& $stable(error_code))
		else $error("stalled result changed");

endmodule

bind mesi_snooping_line_controller msl_checker u_msl_checker (.*);
